// ===== src/rpvg_pkg.sv =====
// ----------------------------------------------------------------------------
// rpvg_pkg
// Shared types, constants and table functions of the regular polygon vertex
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpvg_pkg;

	localparam int unsigned COORD_W = 24;
	localparam int unsigned SIDES_W = 6;
	localparam int unsigned TURN_W  = 16;
	localparam int unsigned INDEX_W = 5;

	localparam logic [SIDES_W-1:0] MIN_SIDES = 6'd3;
	localparam logic [SIDES_W-1:0] MAX_SIDES = 6'd32;

	// One full turn in turn-fraction units, and the quarter-turn phase offset.
	localparam int unsigned      TURN_UNITS   = 65536;
	localparam logic [TURN_W-1:0] QUARTER_TURN = 16'd16384;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Denominators (2n)(2n+1) of the sine Taylor series, n = 1..10.
	localparam longint unsigned TAYLOR_DIV [1:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	typedef logic signed [COORD_W-1:0] coord_t;

	// One classified polygon request, as queued between front and back.
	typedef struct packed {
		coord_t               cx;
		coord_t               cy;
		coord_t               rx;
		coord_t               ry;
		logic [SIDES_W-1:0]   sides;
		logic [TURN_W-1:0]    qstep;
		logic [SIDES_W-1:0]   rstep;
		logic                 empty;
	} desc_t;

	// Quarter-wave sine entry k in Q1.15, evaluated at elaboration only.
	function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned bits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned r;
		int              n;
		x    = (HALF_PI_Q30 * longint'(k)) >> bits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (longint'(sum) + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[14:0];
	endfunction

	// Clamp a 27-bit signed sum into the signed 24-bit coordinate range.
	function automatic coord_t sat_coord(input logic signed [COORD_W+2:0] v);
		if (v > 27'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -27'sd8388608) begin
			return 24'sh800000;
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/rpvg_front.sv =====
// ----------------------------------------------------------------------------
// rpvg_front
// Accepts polygon requests, clamps the side count, flags zero radii and looks
// up the per-vertex turn step (quotient and remainder of one turn by sides).
// ----------------------------------------------------------------------------
`default_nettype none

module rpvg_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire rpvg_pkg::coord_t             center_x,
	input  wire rpvg_pkg::coord_t             center_y,
	input  wire rpvg_pkg::coord_t             radius_x,
	input  wire rpvg_pkg::coord_t             radius_y,
	input  wire logic [rpvg_pkg::SIDES_W-1:0] sides,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output rpvg_pkg::desc_t                   push_desc
);

	localparam int unsigned TAB_DEPTH = 1 << rpvg_pkg::SIDES_W;

	logic [rpvg_pkg::TURN_W-1:0]  q_tab [TAB_DEPTH];
	logic [rpvg_pkg::SIDES_W-1:0] r_tab [TAB_DEPTH];

	for (genvar s = 0; s < TAB_DEPTH; s++) begin : g_step
		localparam int unsigned DIVISOR = (s < 3) ? 3 : s;
		localparam int unsigned QV      = rpvg_pkg::TURN_UNITS / DIVISOR;
		localparam int unsigned RV      = rpvg_pkg::TURN_UNITS % DIVISOR;
		assign q_tab[s] = rpvg_pkg::TURN_W'(QV);
		assign r_tab[s] = rpvg_pkg::SIDES_W'(RV);
	end

	logic [rpvg_pkg::SIDES_W-1:0] clamped;
	rpvg_pkg::desc_t              desc_d;
	rpvg_pkg::desc_t              desc_q;
	logic                         valid_q;
	logic                         accept;

	always_comb begin
		if (sides < rpvg_pkg::MIN_SIDES) begin
			clamped = rpvg_pkg::MIN_SIDES;
		end else if (sides > rpvg_pkg::MAX_SIDES) begin
			clamped = rpvg_pkg::MAX_SIDES;
		end else begin
			clamped = sides;
		end
	end

	always_comb begin
		desc_d.cx    = center_x;
		desc_d.cy    = center_y;
		desc_d.rx    = radius_x;
		desc_d.ry    = radius_y;
		desc_d.sides = clamped;
		desc_d.qstep = q_tab[clamped];
		desc_d.rstep = r_tab[clamped];
		desc_d.empty = (radius_x == '0) || (radius_y == '0);
	end

	assign in_ready   = !valid_q || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = valid_q;
	assign push_desc  = desc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (push_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_q <= desc_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/rpvg_queue.sv =====
// ----------------------------------------------------------------------------
// rpvg_queue
// Two-entry queue of classified polygon requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rpvg_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire rpvg_pkg::desc_t push_desc,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output rpvg_pkg::desc_t      pop_desc
);

	rpvg_pkg::desc_t entries_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_desc   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

// ===== src/rpvg_back.sv =====
// ----------------------------------------------------------------------------
// rpvg_back
// Walks the vertices of one polygon at a time and runs each through a
// four-stage pipeline: turn step, sine table read, multiply, add and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module rpvg_back #(
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         desc_valid,
	output logic                              desc_ready,
	input  wire rpvg_pkg::desc_t              desc,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output rpvg_pkg::coord_t                  vertex_x,
	output rpvg_pkg::coord_t                  vertex_y,
	output logic [rpvg_pkg::INDEX_W-1:0]      vertex_index,
	output logic                              empty_res,
	output logic                              last
);

	localparam int unsigned QUARTER = 1 << SINE_TABLE_BITS;
	localparam int unsigned ADDR_W  = SINE_TABLE_BITS + 1;
	localparam int unsigned SW      = rpvg_pkg::SIDES_W;
	localparam int unsigned TW      = rpvg_pkg::TURN_W;
	localparam int unsigned CW      = rpvg_pkg::COORD_W;

	// Quarter-wave sine table, entries 0..QUARTER inclusive.
	logic [14:0] sine_rom [QUARTER+1];

	for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
		assign sine_rom[k] = rpvg_pkg::sine_entry(k, SINE_TABLE_BITS);
	end

	// Vertex walker.
	rpvg_pkg::desc_t cur_q;
	logic            busy_q;
	logic [SW-1:0]   i_q;
	logic [TW-1:0]   turn_q;
	logic [SW-1:0]   rem_q;
	logic            adv;
	logic            issue;
	logic            is_last;
	logic [SW:0]     rsum;
	logic            wrap;

	// Pipeline stages.
	logic                   valid_s1, valid_s2, valid_s3, valid_s4;
	logic                   empty_s1, empty_s2, empty_s3, empty_s4;
	logic                   last_s1, last_s2, last_s3, last_s4;
	logic [rpvg_pkg::INDEX_W-1:0] index_s1, index_s2, index_s3, index_s4;
	logic [TW-1:0]          ph_s1;
	rpvg_pkg::coord_t       cx_s1, cy_s1, rx_s1, ry_s1;
	rpvg_pkg::coord_t       cx_s2, cy_s2, rx_s2, ry_s2;
	rpvg_pkg::coord_t       cx_s3, cy_s3;
	logic [14:0]            sin_mag_s2, cos_mag_s2;
	logic                   sin_neg_s2, cos_neg_s2;
	logic signed [CW+16:0]  prod_x_s3, prod_y_s3;
	rpvg_pkg::coord_t       vx_s4, vy_s4;

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [ADDR_W-1:0]          sin_addr;
	logic [ADDR_W-1:0]          cos_addr;
	logic signed [16:0]         sin_val;
	logic signed [16:0]         cos_val;
	logic signed [CW+16:0]      round_x, round_y;
	logic signed [CW+2:0]       sum_x, sum_y;

	// The whole pipeline holds while a finished vertex waits at the output.
	assign adv        = !(valid_s4 && !out_ready);
	assign issue      = busy_q && adv;
	assign desc_ready = !busy_q;
	assign is_last    = cur_q.empty || (i_q == cur_q.sides - SW'(1));

	// Turn fraction t_i = round(i * 65536 / sides) kept as quotient and remainder.
	assign rsum = {1'b0, rem_q} + {1'b0, cur_q.rstep};
	assign wrap = (rsum >= {1'b0, cur_q.sides});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			busy_q <= desc_valid;
		end else if (issue && is_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			cur_q  <= desc;
			i_q    <= '0;
			turn_q <= '0;
			rem_q  <= desc.sides >> 1;
		end else if (issue) begin
			i_q    <= i_q + SW'(1);
			turn_q <= turn_q + cur_q.qstep + TW'(wrap);
			rem_q  <= wrap ? SW'(rsum - {1'b0, cur_q.sides}) : rsum[SW-1:0];
		end
	end

	// Stage 1: phase of this vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s1    <= turn_q - rpvg_pkg::QUARTER_TURN;
			empty_s1 <= cur_q.empty;
			last_s1  <= is_last;
			index_s1 <= i_q[rpvg_pkg::INDEX_W-1:0];
			cx_s1    <= cur_q.cx;
			cy_s1    <= cur_q.cy;
			rx_s1    <= cur_q.rx;
			ry_s1    <= cur_q.ry;
		end
	end

	// Stage 2: table read. Odd quadrants read the table mirrored; cosine sits
	// one quadrant ahead of sine.
	assign idx      = ph_s1[13 -: SINE_TABLE_BITS];
	assign sin_addr = ph_s1[14] ? ADDR_W'(QUARTER) - {1'b0, idx} : {1'b0, idx};
	assign cos_addr = ph_s1[14] ? {1'b0, idx} : ADDR_W'(QUARTER) - {1'b0, idx};

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_mag_s2 <= sine_rom[sin_addr];
			cos_mag_s2 <= sine_rom[cos_addr];
			sin_neg_s2 <= ph_s1[15];
			cos_neg_s2 <= ph_s1[15] ^ ph_s1[14];
			empty_s2   <= empty_s1;
			last_s2    <= last_s1;
			index_s2   <= index_s1;
			cx_s2      <= cx_s1;
			cy_s2      <= cy_s1;
			rx_s2      <= rx_s1;
			ry_s2      <= ry_s1;
		end
	end

	// Stage 3: signed product of trig value and radius.
	assign sin_val = sin_neg_s2 ? -$signed({2'b00, sin_mag_s2}) : $signed({2'b00, sin_mag_s2});
	assign cos_val = cos_neg_s2 ? -$signed({2'b00, cos_mag_s2}) : $signed({2'b00, cos_mag_s2});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s3 <= cos_val * rx_s2;
			prod_y_s3 <= sin_val * ry_s2;
			empty_s3  <= empty_s2;
			last_s3   <= last_s2;
			index_s3  <= index_s2;
			cx_s3     <= cx_s2;
			cy_s3     <= cy_s2;
		end
	end

	// Stage 4: round Q1.15 * Q15.8 back to Q15.8 (half up), add center, saturate.
	assign round_x = prod_x_s3 + (CW+17)'(16384);
	assign round_y = prod_y_s3 + (CW+17)'(16384);
	assign sum_x   = $signed({{3{cx_s3[CW-1]}}, cx_s3}) + $signed({round_x[CW+16], round_x[CW+16:15]});
	assign sum_y   = $signed({{3{cy_s3[CW-1]}}, cy_s3}) + $signed({round_y[CW+16], round_y[CW+16:15]});

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s4    <= empty_s3 ? '0 : rpvg_pkg::sat_coord(sum_x);
			vy_s4    <= empty_s3 ? '0 : rpvg_pkg::sat_coord(sum_y);
			empty_s4 <= empty_s3;
			last_s4  <= last_s3;
			index_s4 <= index_s3;
		end
	end

	assign out_valid    = valid_s4;
	assign vertex_x     = vx_s4;
	assign vertex_y     = vy_s4;
	assign vertex_index = index_s4;
	assign empty_res    = empty_s4;
	assign last         = last_s4;

endmodule

`default_nettype wire

// ===== src/regular_polygon_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator
// Emits the vertices of a regular polygon inscribed in an axis-aligned ellipse.
// ----------------------------------------------------------------------------
// Each accepted request yields one vertex per side (side count clamped to
// 3..32), in order from the top, with last set on the final vertex; a zero
// radius yields a single all-zero result with empty_res and last set. The back
// end produces one vertex per cycle unless out_ready stalls it, and goes
// idle between polygons to take the next request from its two-entry queue;
// the walker sets the sustained rate. The front end keeps accepting requests
// while the queue has room. A request passes the front-end register, the
// queue, the walker and the pipeline stages before its first result appears.
`default_nettype none

module regular_polygon_vertex_generator #(
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [23:0]           center_x,
	input  wire logic signed [23:0]           center_y,
	input  wire logic signed [23:0]           radius_x,
	input  wire logic signed [23:0]           radius_y,
	input  wire logic [5:0]                   sides,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [23:0]                vertex_x,
	output logic signed [23:0]                vertex_y,
	output logic [4:0]                        vertex_index,
	output logic                              empty_res,
	output logic                              last
);

	logic            push_valid;
	logic            push_ready;
	rpvg_pkg::desc_t push_desc;
	logic            pop_valid;
	logic            pop_ready;
	rpvg_pkg::desc_t pop_desc;

	rpvg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius_x   (radius_x),
		.radius_y   (radius_y),
		.sides      (sides),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	rpvg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	rpvg_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_valid   (pop_valid),
		.desc_ready   (pop_ready),
		.desc         (pop_desc),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_index (vertex_index),
		.empty_res    (empty_res),
		.last         (last)
	);

endmodule

`default_nettype wire

// ===== bench/regular_polygon_vertex_generator_test.sv =====
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator_test
// Checks every vertex of every polygon that the generator emits.
// ----------------------------------------------------------------------------
// A short table of hand-picked polygons covers the side-count clamp, zero and
// negative radii and coordinate saturation. Several hundred random polygons
// follow. A bench model computes each vertex the table lacks; every output
// transfer is compared field by field against the oldest pending vertex.
// Both channels stall at random, with calm stretches where they do not.
`default_nettype none

module regular_polygon_vertex_generator_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TABLE_BITS    = 10;
	localparam int unsigned QUARTER_STEPS = 1 << TABLE_BITS;
	localparam int unsigned NUM_DIRECTED  = 22;
	localparam int unsigned NUM_RANDOM    = 330;

	typedef struct packed {
		rpvg_pkg::coord_t             x;
		rpvg_pkg::coord_t             y;
		logic [rpvg_pkg::INDEX_W-1:0] index;
		logic                         empty;
		logic                         last;
	} vertex_t;

	typedef struct packed {
		rpvg_pkg::coord_t             cx;
		rpvg_pkg::coord_t             cy;
		rpvg_pkg::coord_t             rx;
		rpvg_pkg::coord_t             ry;
		logic [rpvg_pkg::SIDES_W-1:0] sides;
		logic                         typed;
		vertex_t                      result;
	} polygon_row_t;

	localparam vertex_t EMPTY_VERTEX = '{24'sd0, 24'sd0, 5'd0, 1'b1, 1'b1};
	localparam vertex_t NO_VERTEX    = '0;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	rpvg_pkg::coord_t             center_x = '0;
	rpvg_pkg::coord_t             center_y = '0;
	rpvg_pkg::coord_t             radius_x = '0;
	rpvg_pkg::coord_t             radius_y = '0;
	logic [rpvg_pkg::SIDES_W-1:0] sides = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	rpvg_pkg::coord_t             vertex_x;
	rpvg_pkg::coord_t             vertex_y;
	logic [rpvg_pkg::INDEX_W-1:0] vertex_index;
	logic                         empty_res;
	logic                         last;

	int                   quarter_sine [0:QUARTER_STEPS];
	vertex_t              vertex_expect_q [$];
	int                   mismatch_count = 0;
	bit                   sender_calm = 1'b0;
	polygon_row_t         directed_rows [NUM_DIRECTED];

	regular_polygon_vertex_generator #(
		.SINE_TABLE_BITS(TABLE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.center_x(center_x),
		.center_y(center_y),
		.radius_x(radius_x),
		.radius_y(radius_y),
		.sides(sides),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.vertex_index(vertex_index),
		.empty_res(empty_res),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Generous ceiling, several times the slowest legal run.
	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int sine_of_phase(input logic [rpvg_pkg::TURN_W-1:0] phase);
		int unsigned idx;
		int          mag;
		idx = int'(phase[13:0]) >> (14 - TABLE_BITS);
		mag = phase[14] ? quarter_sine[QUARTER_STEPS - idx] : quarter_sine[idx];
		return phase[15] ? -mag : mag;
	endfunction

	// Q1.15 times Q15.8, rounded half up to Q15.8, offset and saturated.
	function automatic rpvg_pkg::coord_t place_coord(input rpvg_pkg::coord_t center,
			input int trig, input rpvg_pkg::coord_t radius);
		longint prod;
		longint total;
		prod  = longint'(trig) * longint'(radius);
		total = longint'(center) + ((prod + 64'sd16384) >>> 15);
		if (total > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end
		if (total < -64'sd8388608) begin
			return 24'sh800000;
		end
		return total[rpvg_pkg::COORD_W-1:0];
	endfunction

	function automatic void predict_polygon(input rpvg_pkg::coord_t cx,
			input rpvg_pkg::coord_t cy, input rpvg_pkg::coord_t rx,
			input rpvg_pkg::coord_t ry, input logic [rpvg_pkg::SIDES_W-1:0] req_sides);
		int unsigned                 n;
		int unsigned                 turn;
		logic [rpvg_pkg::TURN_W-1:0] phase;
		vertex_t                     v;
		if (rx == 0 || ry == 0) begin
			vertex_expect_q.push_back(EMPTY_VERTEX);
			return;
		end
		n = req_sides;
		if (n < rpvg_pkg::MIN_SIDES) begin
			n = rpvg_pkg::MIN_SIDES;
		end
		if (n > rpvg_pkg::MAX_SIDES) begin
			n = rpvg_pkg::MAX_SIDES;
		end
		for (int unsigned i = 0; i < n; i++) begin
			turn    = (i * rpvg_pkg::TURN_UNITS + n / 2) / n;
			phase   = turn[rpvg_pkg::TURN_W-1:0] - rpvg_pkg::QUARTER_TURN;
			v.x     = place_coord(cx, sine_of_phase(phase + rpvg_pkg::QUARTER_TURN), rx);
			v.y     = place_coord(cy, sine_of_phase(phase), ry);
			v.index = i[rpvg_pkg::INDEX_W-1:0];
			v.empty = 1'b0;
			v.last  = (i + 1 == n);
			vertex_expect_q.push_back(v);
		end
	endfunction

	function automatic rpvg_pkg::coord_t draw_radius();
		int unsigned r;
		case ($urandom_range(0, 15))
			0: return '0;
			1: return 24'sh7FFFFF;
			2: return 24'sh800000;
			3, 4, 5, 6: begin
				r = $urandom_range(1, 4095);
				return $urandom_range(0, 1) ? -rpvg_pkg::coord_t'(r) : rpvg_pkg::coord_t'(r);
			end
			default: return rpvg_pkg::coord_t'($urandom());
		endcase
	endfunction

	function automatic rpvg_pkg::coord_t draw_center();
		case ($urandom_range(0, 11))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return '0;
			default: return rpvg_pkg::coord_t'($urandom());
		endcase
	endfunction

	function automatic int sender_gap();
		if ($urandom_range(0, 29) == 0) begin
			sender_calm = !sender_calm;
		end
		return sender_calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Returns at the edge where the request transfer took place.
	task automatic put_request(input rpvg_pkg::coord_t cx, input rpvg_pkg::coord_t cy,
			input rpvg_pkg::coord_t rx, input rpvg_pkg::coord_t ry,
			input logic [rpvg_pkg::SIDES_W-1:0] n, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		center_x <= cx;
		center_y <= cy;
		radius_x <= rx;
		radius_y <= ry;
		sides    <= n;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_pending();
		in_valid <= 1'b0;
		do @(posedge clk); while (vertex_expect_q.size() != 0);
	endtask

	initial begin : vertex_sink
		int      stall;
		bit      calm;
		vertex_t want;
		calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 59) == 0) begin
				calm = !calm;
			end
			stall = calm ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (vertex_expect_q.size() == 0) begin
				$display("%0t: unexpected transfer, got x=%0d y=%0d index=%0d",
					$time, vertex_x, vertex_y, vertex_index);
				mismatch_count++;
			end else begin
				want = vertex_expect_q.pop_front();
				check_field("vertex_x", want.x, vertex_x);
				check_field("vertex_y", want.y, vertex_y);
				check_field("vertex_index", want.index, vertex_index);
				check_field("empty_res", want.empty, empty_res);
				check_field("last", want.last, last);
			end
		end
	end

	initial begin : polygon_source
		longint unsigned  x;
		longint unsigned  x2;
		longint unsigned  term;
		longint           acc;
		longint           r;
		rpvg_pkg::coord_t cx;
		rpvg_pkg::coord_t cy;

		// Quarter-wave sine in Q1.15 from an eleven-term Taylor series in Q2.30.
		for (int unsigned k = 0; k <= QUARTER_STEPS; k++) begin
			x    = rpvg_pkg::HALF_PI_Q30 * k / QUARTER_STEPS;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (longint unsigned n = 1; n <= 10; n++) begin
				term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
				acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) begin
				acc = 0;
			end
			r = (acc + 16384) >>> 15;
			quarter_sine[k] = (r > 32767) ? 32767 : int'(r);
		end

		directed_rows = '{
			'{24'sd0, 24'sd0, 24'sd0, 24'sd256, 6'd5, 1'b1, EMPTY_VERTEX},
			'{24'sh7FFFFF, 24'sh800000, 24'sd1000, 24'sd0, 6'd32, 1'b1, EMPTY_VERTEX},
			'{24'sh800000, 24'sh7FFFFF, 24'sd0, 24'sd0, 6'd0, 1'b1, EMPTY_VERTEX},
			'{24'sd0, 24'sd0, 24'sd0, -24'sd256, 6'd63, 1'b1, EMPTY_VERTEX},
			'{24'sd0, 24'sd0, 24'sd256, 24'sd256, 6'd0, 1'b0, NO_VERTEX},
			'{24'sd100, -24'sd100, 24'sd512, 24'sd768, 6'd1, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sd256, 24'sd256, 6'd2, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sd256, 24'sd256, 6'd3, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sd1000, 24'sd2000, 6'd4, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sh010000, 24'sh010000, 6'd32, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sh010000, 24'sh008000, 6'd33, 1'b0, NO_VERTEX},
			'{-24'sd5000, 24'sd5000, 24'sd3000, 24'sd3000, 6'd63, 1'b0, NO_VERTEX},
			'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 6'd32, 1'b0, NO_VERTEX},
			'{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 6'd32, 1'b0, NO_VERTEX},
			'{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 6'd8, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, -24'sd256, -24'sd512, 6'd6, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sd1, -24'sd1, 6'd5, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sd1, 24'sd1, 6'd7, 1'b0, NO_VERTEX},
			'{24'sd123456, -24'sd654321, 24'sd400000, 24'sd400000, 6'd31, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sh800000, 24'sh7FFFFF, 6'd17, 1'b0, NO_VERTEX},
			'{24'sh3FFFFF, 24'shC00000, 24'sh555555, 24'shAAAAAA, 6'd9, 1'b0, NO_VERTEX},
			'{24'sd0, 24'sd0, 24'sh7FFFFF, 24'sd1, 6'd62, 1'b0, NO_VERTEX}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			put_request(directed_rows[i].cx, directed_rows[i].cy, directed_rows[i].rx,
				directed_rows[i].ry, directed_rows[i].sides, sender_gap());
			if (directed_rows[i].typed) begin
				vertex_expect_q.push_back(directed_rows[i].result);
			end else begin
				predict_polygon(directed_rows[i].cx, directed_rows[i].cy,
					directed_rows[i].rx, directed_rows[i].ry, directed_rows[i].sides);
			end
		end
		drain_pending();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			cx = draw_center();
			cy = draw_center();
			put_request(cx, cy, draw_radius(), draw_radius(),
				rpvg_pkg::SIDES_W'($urandom_range(0, 63)), sender_gap());
			// The radii are read back from the driven ports, which hold the
			// values of the transfer that just took place.
			predict_polygon(cx, cy, radius_x, radius_y, sides);
			if (i == NUM_RANDOM / 2) begin
				drain_pending();
			end
		end

		in_valid <= 1'b0;
		while (vertex_expect_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
